>>> rtl/core/usc_pkg.sv
package usc_pkg;

  localparam int unsigned SEC_PER_MIN       = 60;
  localparam int unsigned MIN_PER_HOUR      = 60;
  localparam int unsigned HOUR_PER_DAY      = 24;
  localparam int unsigned SEC_PER_HOUR      = SEC_PER_MIN * MIN_PER_HOUR;
  localparam int unsigned SEC_PER_DAY       = SEC_PER_HOUR * HOUR_PER_DAY;
  localparam int unsigned EPOCH_YEAR        = 1970;
  localparam int unsigned DAYS_YEAR         = 365;
  localparam int unsigned DAYS_LEAP         = 366;
  localparam int unsigned SEC_PER_YEAR      = DAYS_YEAR * SEC_PER_DAY;
  localparam int unsigned SEC_PER_LEAP_YEAR = DAYS_LEAP * SEC_PER_DAY;
  localparam logic [3:0]  FEB_INDEX         = 4'd1;
  localparam logic [3:0]  LAST_MONTH        = 4'd11;

  localparam logic [21:0] MONTH_SECS_31 = 22'(31 * SEC_PER_DAY);
  localparam logic [21:0] MONTH_SECS_30 = 22'(30 * SEC_PER_DAY);
  localparam logic [21:0] MONTH_SECS_29 = 22'(29 * SEC_PER_DAY);
  localparam logic [21:0] MONTH_SECS_28 = 22'(28 * SEC_PER_DAY);

  // Residues of the epoch year, used to seed the leap-year tracker.
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_MINUTE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic init;
    logic step;
  } leap_ctl_t;

  // Length of a month in seconds.
  function automatic logic [21:0] month_secs(input logic [3:0] month, input logic leap);
    logic [21:0] len;
    case (month)
      4'd0:      len = MONTH_SECS_31;
      FEB_INDEX: len = leap ? MONTH_SECS_29 : MONTH_SECS_28;
      4'd2:      len = MONTH_SECS_31;
      4'd3:      len = MONTH_SECS_30;
      4'd4:      len = MONTH_SECS_31;
      4'd5:      len = MONTH_SECS_30;
      4'd6:      len = MONTH_SECS_31;
      4'd7:      len = MONTH_SECS_31;
      4'd8:      len = MONTH_SECS_30;
      4'd9:      len = MONTH_SECS_31;
      4'd10:     len = MONTH_SECS_30;
      4'd11:     len = MONTH_SECS_31;
      default:   len = MONTH_SECS_31;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/core/unix_seconds_to_calendar_date.sv
// Converts a count of seconds since 1970-01-01 00:00:00 into the Gregorian
// date and time of day. One word is converted at a time; in_stall is high from
// acceptance until the result word is taken. A single subtract-and-compare unit
// does all the work on the remaining seconds: whole years are removed one per
// cycle, then months, days, hours and minutes, one per cycle each, and what is
// left is the second. The block returns to idle once the result word is
// taken, and it accepts the next word from there.
module unix_seconds_to_calendar_date #(
  parameter int unsigned SECONDS_WIDTH = 34
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SECONDS_WIDTH-1:0] in_unix_seconds,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [11:0]              out_year,
  output logic [3:0]               out_month,
  output logic [4:0]               out_day_of_month,
  output logic [4:0]               out_hour,
  output logic [5:0]               out_minute,
  output logic [5:0]               out_second
);
  import usc_pkg::*;

  state_t state_r, state_nxt;

  logic [SECONDS_WIDTH-1:0] rem_r;
  logic [11:0]              year_r;
  logic [3:0]               month_r;
  logic [4:0]               mday_r;
  logic [4:0]               hour_r;
  logic [5:0]               minute_r;

  // Shared subtract-and-compare unit, always working on the remaining seconds.
  logic [SECONDS_WIDTH-1:0] op_b;
  logic [SECONDS_WIDTH:0]   diff;
  logic                     ge;

  logic                     leap;
  leap_ctl_t                leap_ctl;
  logic                     in_take;
  logic                     month_go;

  assign diff = {1'b0, rem_r} - {1'b0, op_b};
  assign ge   = !diff[SECONDS_WIDTH];

  assign in_take  = in_valid && !in_stall;
  assign month_go = (month_r != LAST_MONTH) && ge;

  usc_leap u_leap (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (leap_ctl),
    .leap  (leap)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_YEAR;
      ST_YEAR:   if (!ge) state_nxt = ST_MONTH;
      ST_MONTH:  if (!month_go) state_nxt = ST_DAY;
      ST_DAY:    if (!ge) state_nxt = ST_HOUR;
      ST_HOUR:   if (!ge) state_nxt = ST_MINUTE;
      ST_MINUTE: if (!ge) state_nxt = ST_DONE;
      ST_DONE:   if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and unit operand selection.
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    op_b          = '0;
    leap_ctl.init = 1'b0;
    leap_ctl.step = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        leap_ctl.init = in_valid;
      end
      ST_YEAR: begin
        op_b          = leap ? SECONDS_WIDTH'(SEC_PER_LEAP_YEAR) :
                               SECONDS_WIDTH'(SEC_PER_YEAR);
        leap_ctl.step = ge;
      end
      ST_MONTH: begin
        op_b = SECONDS_WIDTH'(month_secs(month_r, leap));
      end
      ST_DAY: begin
        op_b = SECONDS_WIDTH'(SEC_PER_DAY);
      end
      ST_HOUR: begin
        op_b = SECONDS_WIDTH'(SEC_PER_HOUR);
      end
      ST_MINUTE: begin
        op_b = SECONDS_WIDTH'(SEC_PER_MIN);
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          rem_r    <= in_unix_seconds;
          year_r   <= 12'(EPOCH_YEAR);
          month_r  <= '0;
          mday_r   <= '0;
          hour_r   <= '0;
          minute_r <= '0;
        end
      end
      ST_YEAR: begin
        if (ge) begin
          rem_r  <= diff[SECONDS_WIDTH-1:0];
          year_r <= year_r + 12'd1;
        end
      end
      ST_MONTH: begin
        if (month_go) begin
          rem_r   <= diff[SECONDS_WIDTH-1:0];
          month_r <= month_r + 4'd1;
        end
      end
      ST_DAY: begin
        if (ge) begin
          rem_r  <= diff[SECONDS_WIDTH-1:0];
          mday_r <= mday_r + 5'd1;
        end
      end
      ST_HOUR: begin
        if (ge) begin
          rem_r  <= diff[SECONDS_WIDTH-1:0];
          hour_r <= hour_r + 5'd1;
        end
      end
      ST_MINUTE: begin
        if (ge) begin
          rem_r    <= diff[SECONDS_WIDTH-1:0];
          minute_r <= minute_r + 6'd1;
        end
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  // The walk counts whole days; the word reports the day one-based.
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day_of_month = mday_r + 5'd1;
  assign out_hour         = hour_r;
  assign out_minute       = minute_r;
  assign out_second       = rem_r[5:0];

`ifndef SYNTHESIS
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (hour_r < 5'd24) && (minute_r < 6'd60) &&
    (rem_r < SECONDS_WIDTH'(SEC_PER_MIN)))
    else $error("time of day out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (mday_r < 5'd31) && (month_r <= LAST_MONTH))
    else $error("date out of range");

  a_year_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR) && !ge |=> (state_r == ST_MONTH) && (month_r == 4'd0))
    else $error("year walk did not hand over to month walk");

  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MONTH) && (month_r == FEB_INDEX) |->
    (op_b == SECONDS_WIDTH'(MONTH_SECS_28)) || (op_b == SECONDS_WIDTH'(MONTH_SECS_29)))
    else $error("bad February length");
`endif

endmodule

>>> rtl/core/usc_leap.sv
module usc_leap (
  input  logic                clk,
  input  logic                rst_n,
  input  usc_pkg::leap_ctl_t  ctl,
  output logic                leap
);
  import usc_pkg::*;

  logic [1:0] mod4_r,   mod4_nxt;
  logic [6:0] mod100_r, mod100_nxt;
  logic [8:0] mod400_r, mod400_nxt;

  always_comb begin
    mod4_nxt   = mod4_r;
    mod100_nxt = mod100_r;
    mod400_nxt = mod400_r;
    if (ctl.init) begin
      mod4_nxt   = EPOCH_MOD4;
      mod100_nxt = EPOCH_MOD100;
      mod400_nxt = EPOCH_MOD400;
    end else if (ctl.step) begin
      mod4_nxt   = mod4_r + 2'd1;
      mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
      mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod4_r   <= EPOCH_MOD4;
      mod100_r <= EPOCH_MOD100;
      mod400_r <= EPOCH_MOD400;
    end else begin
      mod4_r   <= mod4_nxt;
      mod100_r <= mod100_nxt;
      mod400_r <= mod400_nxt;
    end
  end

  assign leap = (mod4_r == 2'd0) && ((mod100_r != 7'd0) || (mod400_r == 9'd0));

endmodule
